>>> rtl/core/itaf_pkg.sv
// ============================================================================
// itaf_pkg: shared types and constants of the integer to ascii formatter
// Field widths, format codes, ascii codes and the hand-off record passed
// from the decimal converter to the character emitter.
// ============================================================================
package itaf_pkg;

  // field widths
  localparam int CmdW    = 3;
  localparam int ValueW  = 32;
  localparam int WidthW  = 4;
  localparam int CharW   = 8;
  localparam int HalfW   = 16;

  // decimal digit store
  localparam int NumDigits  = 10;
  localparam int DigitW     = 4;
  localparam int BcdW       = NumDigits * DigitW;
  localparam int HexDigits  = 4;
  localparam int HexW       = HexDigits * DigitW;
  localparam int ShortStart = 5;
  localparam int RemW       = $clog2(NumDigits + 1);

  // shift-and-add-3 converter: bits consumed per cycle and cycle count
  localparam int StepBits  = 4;
  localparam int ConvSteps = ValueW / StepBits;
  localparam int CntW      = $clog2(ConvSteps);

  // format codes
  localparam logic [CmdW-1:0] CmdS16 = 3'd0;
  localparam logic [CmdW-1:0] CmdU16 = 3'd1;
  localparam logic [CmdW-1:0] CmdS32 = 3'd2;
  localparam logic [CmdW-1:0] CmdU32 = 3'd3;
  localparam logic [CmdW-1:0] CmdHex = 3'd4;

  // ascii codes
  localparam logic [CharW-1:0] AsciiZero   = 8'h30;
  localparam logic [CharW-1:0] AsciiUpperA = 8'h41;
  localparam logic [CharW-1:0] AsciiMinus  = 8'h2D;

  typedef enum logic [1:0] {
    CvIdle,
    CvRun,
    CvDone
  } conv_state_e;

  // one converted number, most significant digit in the top nibble
  typedef struct packed {
    logic [BcdW-1:0]   digits;
    logic              neg;
    logic              hex;
    logic              short_fmt;
    logic [WidthW-1:0] width;
  } itaf_job_t;

endpackage

>>> rtl/core/itaf_in_if.sv
// ============================================================================
// itaf_in_if: input channel of the formatter
// Valid/ready channel carrying the format command, the number and the
// minimum digit count.
// ============================================================================
interface itaf_in_if import itaf_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [ValueW-1:0] value;
  logic [WidthW-1:0] width;

  modport source (output valid, command, value, width, input ready);
  modport sink   (input valid, command, value, width, output ready);

endinterface

>>> rtl/core/itaf_out_if.sv
// ============================================================================
// itaf_out_if: output channel of the formatter
// Valid/ready channel carrying one ascii character and its last flag.
// ============================================================================
interface itaf_out_if import itaf_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic             last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);

endinterface

>>> rtl/core/itaf_conv.sv
// ============================================================================
// itaf_conv: binary to bcd converter
// Takes one input beat, forms the magnitude and runs shift-and-add-3 over
// it, four bits a cycle, into ten bcd digits. Hex bypasses the conversion.
// ============================================================================
module itaf_conv import itaf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  itaf_in_if.sink   in_i,
  output logic      job_valid_o,
  output itaf_job_t job_o,
  input  logic      job_ready_i
);

  conv_state_e       state_q, state_d;
  logic [CntW-1:0]   cnt_q;
  logic [ValueW-1:0] bin_q, bin_w;
  logic [BcdW-1:0]   bcd_q, bcd_w;
  logic              neg_q, hex_q, short_q;
  logic [WidthW-1:0] width_q;

  logic              accept;
  logic              cmd_ok, is16, is_hex, is_neg;
  logic [HalfW-1:0]  v16;
  logic [ValueW-1:0] mag;

  assign accept = in_i.valid && in_i.ready;

  // decode the incoming command and form the magnitude
  always_comb begin
    cmd_ok = (in_i.command == CmdS16) || (in_i.command == CmdU16) ||
             (in_i.command == CmdS32) || (in_i.command == CmdU32) ||
             (in_i.command == CmdHex);
    is16   = (in_i.command == CmdS16) || (in_i.command == CmdU16);
    is_hex = (in_i.command == CmdHex);
    is_neg = ((in_i.command == CmdS16) && in_i.value[HalfW-1]) ||
             ((in_i.command == CmdS32) && in_i.value[ValueW-1]);
    v16    = in_i.value[HalfW-1:0];
    if (is16) begin
      mag = ValueW'(is_neg ? HalfW'(~v16 + 1'b1) : v16);
    end else begin
      mag = is_neg ? ValueW'(~in_i.value + 1'b1) : in_i.value;
    end
  end

  // four shift-and-add-3 steps per cycle
  always_comb begin
    bcd_w = bcd_q;
    bin_w = bin_q;
    for (int s = 0; s < StepBits; s++) begin
      for (int j = 0; j < NumDigits; j++) begin
        if (bcd_w[j*DigitW +: DigitW] >= 4'd5) begin
          bcd_w[j*DigitW +: DigitW] = bcd_w[j*DigitW +: DigitW] + 4'd3;
        end
      end
      bcd_w = {bcd_w[BcdW-2:0], bin_w[ValueW-1]};
      bin_w = {bin_w[ValueW-2:0], 1'b0};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CvIdle: begin
        if (accept && cmd_ok) begin
          state_d = is_hex ? CvDone : CvRun;
        end
      end
      CvRun: begin
        if (cnt_q == CntW'(ConvSteps - 1)) begin
          state_d = CvDone;
        end
      end
      CvDone: begin
        if (job_ready_i) begin
          state_d = CvIdle;
        end
      end
      default: state_d = CvIdle;
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready      = (state_q == CvIdle);
    job_valid_o     = (state_q == CvDone);
    job_o.digits    = bcd_q;
    job_o.neg       = neg_q;
    job_o.hex       = hex_q;
    job_o.short_fmt = short_q;
    job_o.width     = width_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CvIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == CvRun) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bin_q   <= is_hex ? '0 : mag;
      bcd_q   <= is_hex ? BcdW'(in_i.value[HexW-1:0]) : '0;
      neg_q   <= is_neg;
      hex_q   <= is_hex;
      short_q <= is16 && (mag != '0);
      width_q <= in_i.width;
    end else if (state_q == CvRun) begin
      bin_q <= bin_w;
      bcd_q <= bcd_w;
    end
  end

  // unused commands are dropped at once
  a_drop_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cmd_ok) |=> (state_q == CvIdle))
    else $error("unused command did not return to idle");

  // conversion ends after a fixed number of steps
  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CvRun && cnt_q == CntW'(ConvSteps - 1)) |=> (state_q == CvDone))
    else $error("conversion overran its step count");

  // hex goes straight to hand-off
  a_hex_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_hex) |=> job_valid_o)
    else $error("hex beat not handed off next cycle");

  // hand-off frees the input side
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_o && job_ready_i) |=> in_i.ready)
    else $error("input not ready after hand-off");

endmodule

>>> rtl/core/itaf_emit.sv
// ============================================================================
// itaf_emit: character emitter
// Picks the digit positions to print, aligns them in a digit shift register
// and sends one ascii character per beat, minus sign first.
// ============================================================================
module itaf_emit import itaf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  itaf_job_t   job_i,
  output logic        job_ready_o,
  itaf_out_if.source  out_o
);

  logic [BcdW-1:0]      dig_q, dig_d;
  logic                 neg_q, neg_d;
  logic [RemW-1:0]      rem_q, rem_d;

  logic                 busy, last_beat, out_acc, load;
  logic                 nz;
  logic [NumDigits-1:0] mask;
  logic [RemW-1:0]      k;
  logic [BcdW-1:0]      aligned;

  function automatic logic [CharW-1:0] nib_char(logic [DigitW-1:0] nib);
    if (nib < 4'd10) begin
      return AsciiZero + CharW'(nib);
    end
    return AsciiUpperA + CharW'(nib - 4'd10);
  endfunction

  assign busy        = neg_q || (rem_q != '0);
  assign last_beat   = !neg_q && (rem_q == RemW'(1));
  assign out_acc     = out_o.valid && out_o.ready;
  assign job_ready_o = !busy || (out_acc && last_beat);
  assign load        = job_valid_i && job_ready_o;

  // select printed positions: a suffix of the ten digits
  always_comb begin
    nz   = 1'b0;
    k    = '0;
    mask = '0;
    for (int p = 0; p < NumDigits; p++) begin
      nz = nz | (job_i.digits[BcdW-1-p*DigitW -: DigitW] != '0);
      if (job_i.hex) begin
        mask[p] = (p >= NumDigits - HexDigits);
      end else begin
        mask[p] = (p >= (job_i.short_fmt ? ShortStart : 0)) &&
                  (nz || (int'(job_i.width) >= NumDigits - p));
      end
      k = k + RemW'(mask[p]);
    end
    aligned = job_i.digits << (DigitW * (NumDigits - int'(k)));
  end

  // next values of the digit shift register
  always_comb begin
    dig_d = dig_q;
    neg_d = neg_q;
    rem_d = rem_q;
    if (load) begin
      dig_d = aligned;
      neg_d = job_i.neg;
      rem_d = k;
    end else if (out_acc) begin
      if (neg_q) begin
        neg_d = 1'b0;
      end else begin
        rem_d = rem_q - 1'b1;
        dig_d = dig_q << DigitW;
      end
    end
  end

  // output beat
  always_comb begin
    out_o.valid     = busy;
    out_o.last      = last_beat;
    out_o.character = neg_q ? AsciiMinus : nib_char(dig_q[BcdW-1 -: DigitW]);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q <= 1'b0;
      rem_q <= '0;
    end else begin
      neg_q <= neg_d;
      rem_q <= rem_d;
    end
  end

  // digit shift register
  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

  // never more digits than positions
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= RemW'(NumDigits))
    else $error("digit count out of range");

  // a minus sign is always followed by a digit
  a_neg_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    neg_q |-> (rem_q != '0))
    else $error("minus sign without digits");

  // output goes quiet after the last beat unless a new number was loaded
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_beat && !load) |=> !busy)
    else $error("output still valid after last beat");

endmodule

>>> rtl/core/integer_to_ascii_formatter_top.sv
// ============================================================================
// integer_to_ascii_formatter_top: number to ascii character stream
// Formats one number as signed/unsigned 16/32-bit decimal or 4-digit hex.
// ============================================================================
// A number is taken when the converter is idle. Decimal formats then run
// through the shift-and-add-3 converter (4 bits a cycle) and wait in
// hand-off until the emitter takes them; hex skips the conversion. The
// converter takes a new number only after handing off the last one. The
// emitter sends one character per beat, up to 11 per number (minus sign plus
// ten digits), and works on one number while the converter works on the next.
// The first character is ready once the number is handed off to the emitter.
// Unused commands, and decimal zero with a width of zero, give no output.
module integer_to_ascii_formatter_top import itaf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  itaf_in_if.sink    in_i,
  itaf_out_if.source out_o
);

  logic      job_valid;
  logic      job_ready;
  itaf_job_t job;

  // binary to bcd
  itaf_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  // character stream
  itaf_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .out_o       (out_o)
  );

endmodule

>>> sim/integer_to_ascii_formatter_top_tb.sv
// ============================================================================
// integer_to_ascii_formatter_top_tb: self-checking bench of the formatter
// Sends numbers with format commands and widths over the input channel and
// checks every ascii beat against spelled-out text or a predictor. A directed
// table comes first, then random items, with random idle bursts on both channels.
// ============================================================================
`timescale 1ns / 1ps

module integer_to_ascii_formatter_top_tb;
  import itaf_pkg::*;

  // spare format codes, ignored by the block
  localparam logic [CmdW-1:0] CmdRsv5 = 3'd5;
  localparam logic [CmdW-1:0] CmdRsv6 = 3'd6;
  localparam logic [CmdW-1:0] CmdRsv7 = 3'd7;

  localparam int RandomItems = 270;
  localparam int QuietItems  = 40;
  localparam int DrainItem   = 150;
  localparam int TailCycles  = 40;
  localparam int MaxReports  = 10;
  localparam int CycleLimit  = 400000;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last;
  } char_beat_t;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [ValueW-1:0] value;
    logic [WidthW-1:0] width;
    logic              typed;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  itaf_in_if  in_if ();
  itaf_out_if out_if ();

  integer_to_ascii_formatter_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  char_beat_t char_q [$];
  stim_row_t  dir_rows [$];
  string      dir_text [$];

  int fail_count  = 0;
  int cycle_count = 0;
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("integer_to_ascii_formatter_top_tb: errors");
      $finish;
    end
  end

  // power of ten for digit position k, 10^9 at position 0
  function automatic logic [ValueW-1:0] digit_weight(input int k);
    logic [ValueW-1:0] p;
    p = 1;
    repeat (NumDigits - 1 - k) p = p * 10;
    return p;
  endfunction

  // characters of one number, queued with the last flag on the final one
  function automatic void format_number(input logic [CmdW-1:0]   cmd,
                                        input logic [ValueW-1:0] val,
                                        input logic [WidthW-1:0] wid);
    logic [CharW-1:0]  text [$];
    logic [ValueW-1:0] mag;
    logic [CharW-1:0]  c;
    logic [DigitW-1:0] nib;
    int                pos;
    int                n;
    text = {};
    pos  = 0;
    mag  = val;
    if (cmd == CmdHex) begin
      for (int sh = HexDigits - 1; sh >= 0; sh--) begin
        nib = val[sh*DigitW +: DigitW];
        text.push_back(nib < 4'd10 ? AsciiZero + nib : AsciiUpperA + nib - 8'd10);
      end
    end else if (cmd <= CmdU32) begin
      // sign and magnitude
      if (cmd == CmdS16 || cmd == CmdU16) begin
        pos = ShortStart;
        mag = {{(ValueW-HalfW){1'b0}}, val[HalfW-1:0]};
        if (cmd == CmdS16 && val[HalfW-1]) begin
          text.push_back(AsciiMinus);
          mag = 32'h0001_0000 - mag;
        end
      end else if (cmd == CmdS32 && val[ValueW-1]) begin
        text.push_back(AsciiMinus);
        mag = -val;
      end
      if (mag == 0) begin
        // zero run, saturating at ten
        n = (wid > NumDigits) ? NumDigits : wid;
        repeat (n) text.push_back(AsciiZero);
      end else begin
        // leading positions, padded only up to the width
        while (pos < NumDigits - 1 && mag < digit_weight(pos)) begin
          if (wid >= NumDigits - pos) text.push_back(AsciiZero);
          pos++;
        end
        // digits by repeated subtraction
        while (pos < NumDigits) begin
          c = AsciiZero;
          while (mag >= digit_weight(pos)) begin
            mag = mag - digit_weight(pos);
            c++;
          end
          text.push_back(c);
          pos++;
        end
      end
    end
    foreach (text[i]) char_q.push_back('{character: text[i], last: i == text.size() - 1});
  endfunction

  // directed row with optional spelled-out result
  task automatic add_row(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] val,
                         input logic [WidthW-1:0] wid, input logic typed,
                         input string text);
    dir_rows.push_back('{cmd: cmd, value: val, width: wid, typed: typed});
    dir_text.push_back(text);
  endtask

  // one input beat, with an optional idle burst ahead of it
  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] val,
                           input logic [WidthW-1:0] wid, input logic typed,
                           input string text);
    int gap;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.value   <= val;
    in_if.width   <= wid;
    do @(posedge clk_i); while (!in_if.ready);
    // beat taken at this edge
    if (typed) begin
      for (int i = 0; i < text.len(); i++)
        char_q.push_back('{character: text[i], last: i == text.len() - 1});
    end else begin
      format_number(cmd, val, wid);
    end
  endtask

  // hold off until every expected character has come
  task automatic drain_outputs();
    in_if.valid <= 1'b0;
    while (char_q.size() != 0) @(posedge clk_i);
  endtask

  // random number with a bias toward edges and short magnitudes
  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] p;
    case ($urandom_range(0, 6))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return '0;
      3: return $urandom_range(0, 20);
      4: begin
        case ($urandom_range(0, 5))
          0: return 32'h8000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h7FFF_FFFF;
          3: return {16'($urandom_range(0, 65535)), 16'h8000};
          4: return {16'($urandom_range(0, 65535)), 16'h7FFF};
          default: return {16'($urandom_range(0, 65535)), 16'hFFFF};
        endcase
      end
      5: begin
        // around a power of ten
        p = 1;
        repeat ($urandom_range(0, NumDigits - 1)) p = p * 10;
        return p + $urandom_range(0, 2) - 1;
      end
      default: return {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 15) << 12)};
    endcase
  endfunction

  // output side: check beats and stall in bursts
  initial begin : rx_side
    int stall_left;
    char_beat_t want;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (char_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("unexpected beat: char %h last %b", out_if.character, out_if.last);
        end else begin
          want = char_q.pop_front();
          if (want.character !== out_if.character || want.last !== out_if.last) begin
            fail_count++;
            if (fail_count <= MaxReports)
              $display("mismatch: expected char %h last %b, got char %h last %b",
                       want.character, want.last, out_if.character, out_if.last);
          end
        end
      end
      if (!rst_ni) begin
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // input side and end of run
  initial begin : tx_side
    int                counted;
    logic [CmdW-1:0]   cmd;
    logic [ValueW-1:0] val;
    logic [WidthW-1:0] wid;
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.command <= CmdS16;
    in_if.value   <= '0;
    in_if.width   <= '0;

    // directed table
    add_row(CmdS16, 32'h0000_0000, 4'd1,  1'b1, "0");
    add_row(CmdS16, 32'h0000_0000, 4'd0,  1'b1, "");
    add_row(CmdU32, 32'h0000_0000, 4'd15, 1'b1, "0000000000");
    add_row(CmdS16, 32'h0000_0000, 4'd12, 1'b1, "0000000000");
    add_row(CmdS16, 32'h0000_8000, 4'd1,  1'b1, "-32768");
    add_row(CmdS16, 32'h0000_FFFF, 4'd1,  1'b1, "-1");
    add_row(CmdS16, 32'h0000_7FFF, 4'd1,  1'b1, "32767");
    add_row(CmdU16, 32'h0000_FFFF, 4'd1,  1'b1, "65535");
    add_row(CmdU16, 32'hABCD_0001, 4'd3,  1'b1, "001");
    add_row(CmdU16, 32'h0000_0001, 4'd9,  1'b1, "00001");
    add_row(CmdS32, 32'h8000_0000, 4'd1,  1'b1, "-2147483648");
    add_row(CmdS32, 32'hFFFF_FFFF, 4'd1,  1'b1, "-1");
    add_row(CmdS32, 32'h7FFF_FFFF, 4'd1,  1'b1, "2147483647");
    add_row(CmdU32, 32'hFFFF_FFFF, 4'd1,  1'b1, "4294967295");
    add_row(CmdU32, 32'h0000_0001, 4'd15, 1'b1, "0000000001");
    add_row(CmdHex, 32'h0000_0000, 4'd0,  1'b1, "0000");
    add_row(CmdHex, 32'hDEAD_BEEF, 4'd15, 1'b1, "BEEF");
    add_row(CmdHex, 32'h1234_A5F0, 4'd4,  1'b1, "A5F0");
    add_row(CmdRsv5, 32'h0000_1234, 4'd5, 1'b1, "");
    add_row(CmdRsv6, 32'hFFFF_FFFF, 4'd9, 1'b1, "");
    add_row(CmdRsv7, 32'h8000_0000, 4'd1, 1'b1, "");
    add_row(CmdU32, 32'd12345,      4'd7, 1'b0, "");
    add_row(CmdS32, -32'sd42,       4'd5, 1'b0, "");
    add_row(CmdS16, 32'h0000_0100,  4'd4, 1'b0, "");
    add_row(CmdU32, 32'd1000000000, 4'd0, 1'b0, "");

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].width,
                dir_rows[i].typed, dir_text[i]);
    drain_outputs();

    // random items, ignored commands do not count
    counted = 0;
    while (counted < RandomItems) begin
      if (counted % 40 == 0 && counted < RandomItems - QuietItems) begin
        tx_idle_on = $urandom_range(0, 2) != 0;
        rx_idle_on = $urandom_range(0, 2) != 0;
      end
      if (counted >= RandomItems - QuietItems) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if ($urandom_range(0, 19) == 0)
        cmd = CmdW'(CmdHex + $urandom_range(1, 3));
      else
        cmd = CmdW'($urandom_range(CmdS16, CmdHex));
      val = pick_value();
      wid = WidthW'($urandom_range(0, 15));
      send_item(cmd, val, wid, 1'b0, "");
      if (cmd <= CmdHex) begin
        counted++;
        if (counted == DrainItem) drain_outputs();
      end
    end

    // wind down
    drain_outputs();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0)
      $display("integer_to_ascii_formatter_top_tb: clean");
    else
      $display("integer_to_ascii_formatter_top_tb: errors");
    $finish;
  end

endmodule
